FILE: hw/rtl/rtdc_pkg.sv
// ----------------------------------------------------------------------------
// rtdc_pkg: shared types and constants of the rtd temperature converter
// fixed-point constants of the inverse pt100 curve, queue and pipeline sizes
// ----------------------------------------------------------------------------
package rtdc_pkg;

  // field widths
  localparam int CODE_W = 15;
  localparam int REF_W  = 12;
  localparam int TEMP_W = 19;

  // configuration port
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_REF_OHMS = 2'd0;
  localparam logic [REF_W-1:0] REF_RESET = 12'd400;

  // discriminant arithmetic
  localparam int N_W = CODE_W + REF_W;   // code * ref
  localparam int P_W = 49;               // slope * n
  localparam int K_W = 46;               // scaled discriminant
  localparam logic [21:0] DISC_SLOPE = 22'd2310000;
  localparam logic [K_W-1:0] DISC_BASE = K_W'(64'd1758480889 << 15);

  // square root
  localparam int RAD_W  = 64;
  localparam int ROOT_W = 32;
  localparam int REM_W  = 35;
  localparam int SQRT_STEPS_PER_STAGE = 2;
  localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS_PER_STAGE;
  localparam int SQRT_SHIFT  = 17;

  // scaling to degrees
  localparam logic [ROOT_W-1:0] A_SCALED = 32'd2561343488;
  localparam logic [6:0]  HUNDRED  = 7'd100;
  localparam logic [25:0] DEN_HALF = 26'd37847040;
  localparam int DEN_SHIFT = 16;
  localparam int DIFF100_W = ROOT_W + 7;
  localparam int Y_W = 29;
  localparam int Q_W = 19;
  localparam logic [Y_W-1:0] SAT_Y = 29'd302777475;    // 262145 * 1155
  localparam logic [10:0] DIV_K = 11'd1155;
  localparam logic [27:0] RECIP = 28'd237989529;       // floor(2^38 / 1155)
  localparam int RECIP_SHIFT = 38;
  localparam int RECIP_PROD_W = Y_W + 28;
  localparam logic [Q_W-1:0] TEMP_POS_MAX = 19'd262143;
  localparam logic [Q_W-1:0] TEMP_NEG_MAG = 19'd262144;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic disc_ok;
    logic fault;
  } rtdc_tag_t;

  typedef struct packed {
    logic [K_W-1:0] disc;
    rtdc_tag_t      tag;
  } rtdc_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rtdc_qstat_t;

endpackage

FILE: hw/rtl/rtdc_ifs.sv
// ----------------------------------------------------------------------------
// rtdc channels: valid/ready interfaces for sensor words and temperatures
// one beat moves per edge with valid and ready both high
// ----------------------------------------------------------------------------
interface rtdc_in_if;
  import rtdc_pkg::*;

  logic        valid;
  logic        ready;
  logic [15:0] rtd_word;
  logic [7:0]  status_byte;

  modport source (output valid, rtd_word, status_byte, input ready);
  modport sink   (input valid, rtd_word, status_byte, output ready);
endinterface

interface rtdc_out_if;
  import rtdc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature;
  logic                     valid_res;
  logic                     fault;

  modport source (output valid, temperature, valid_res, fault, input ready);
  modport sink   (input valid, temperature, valid_res, fault, output ready);
endinterface

FILE: hw/rtl/rtdc_front.sv
// ----------------------------------------------------------------------------
// rtdc_front: accepts sensor beats and forms the scaled discriminant
// two stages: code times reference, then slope product and sign check
// ----------------------------------------------------------------------------
module rtdc_front (
  input  logic                       clk,
  input  logic                       rst,
  rtdc_in_if.sink                    item,
  input  logic [rtdc_pkg::REF_W-1:0] ref_ohms,
  input  rtdc_pkg::rtdc_qstat_t      qstat,
  output logic                       push,
  output rtdc_pkg::rtdc_entry_t      entry
);
  import rtdc_pkg::*;

  logic           en;
  logic           f1_vld;
  logic [N_W-1:0] f1_n;
  logic           f1_fault;
  logic           f2_vld;
  logic [P_W-1:0] f2_p;
  logic           f2_fault;

  assign en = !qstat.full;
  assign item.ready = en;
  assign push = f2_vld && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
      f2_vld <= 1'b0;
    end else if (en) begin
      f1_vld <= item.valid;
      f2_vld <= f1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_n     <= N_W'(item.rtd_word[15:1]) * N_W'(ref_ohms);
      f1_fault <= item.status_byte[7];
      f2_p     <= P_W'(f1_n) * P_W'(DISC_SLOPE);
      f2_fault <= f1_fault;
    end
  end

  // negative discriminant when the slope term passes the base
  always_comb begin
    entry.tag.fault   = f2_fault;
    entry.tag.disc_ok = f2_p <= P_W'(DISC_BASE);
    entry.disc        = K_W'(P_W'(DISC_BASE) - f2_p);
  end

endmodule

FILE: hw/rtl/rtdc_queue.sv
// ----------------------------------------------------------------------------
// rtdc_queue: short fifo between front and back
// decouples the two stall domains
// ----------------------------------------------------------------------------
module rtdc_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rtdc_pkg::rtdc_entry_t wr_entry,
  input  logic                  pop,
  output rtdc_pkg::rtdc_entry_t rd_entry,
  output rtdc_pkg::rtdc_qstat_t qstat
);
  import rtdc_pkg::*;

  rtdc_entry_t         slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;

  assign qstat.full  = count == QUEUE_CW'(QUEUE_DEPTH);
  assign qstat.empty = count == '0;
  assign rd_entry    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

endmodule

FILE: hw/rtl/rtdc_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// rtdc_sqrt_pipe: pipelined integer square root, floor result
// restoring digit recurrence, two root bits per stage
// ----------------------------------------------------------------------------
module rtdc_sqrt_pipe (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [rtdc_pkg::RAD_W-1:0]  in_rad,
  input  rtdc_pkg::rtdc_tag_t         in_tag,
  output logic                        out_valid,
  output logic [rtdc_pkg::ROOT_W-1:0] out_root,
  output rtdc_pkg::rtdc_tag_t         out_tag
);
  import rtdc_pkg::*;

  logic              vld_q  [SQRT_STAGES];
  logic [REM_W-1:0]  rem_q  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_q [SQRT_STAGES];
  logic [RAD_W-1:0]  rad_q  [SQRT_STAGES];
  rtdc_tag_t         tag_q  [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    logic              vld_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    rtdc_tag_t         tag_in;
    logic [REM_W-1:0]  rem_v;
    logic [ROOT_W-1:0] root_v;
    logic [RAD_W-1:0]  rad_v;
    logic [REM_W-1:0]  trial;

    if (s == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad;
      assign tag_in  = in_tag;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign tag_in  = tag_q[s-1];
    end

    always_comb begin
      rem_v  = rem_in;
      root_v = root_in;
      rad_v  = rad_in;
      trial  = '0;
      for (int j = 0; j < SQRT_STEPS_PER_STAGE; j++) begin
        rem_v = {rem_v[REM_W-3:0], rad_v[RAD_W-1 -: 2]};
        rad_v = {rad_v[RAD_W-3:0], 2'b00};
        trial = REM_W'({root_v, 2'b01});
        if (rem_v >= trial) begin
          rem_v  = rem_v - trial;
          root_v = {root_v[ROOT_W-2:0], 1'b1};
        end else begin
          root_v = {root_v[ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s]  <= rem_v;
        root_q[s] <= root_v;
        rad_q[s]  <= rad_v;
        tag_q[s]  <= tag_in;
      end
    end
  end

  assign out_valid = vld_q[SQRT_STAGES-1];
  assign out_root  = root_q[SQRT_STAGES-1];
  assign out_tag   = tag_q[SQRT_STAGES-1];

endmodule

FILE: hw/rtl/rtdc_back.sv
// ----------------------------------------------------------------------------
// rtdc_back: square root, scaling to degrees and result register
// whole back pipeline moves while the result register is free
// ----------------------------------------------------------------------------
module rtdc_back #(
  parameter int TEMP_FRAC_BITS = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rtdc_pkg::rtdc_entry_t head,
  input  rtdc_pkg::rtdc_qstat_t qstat,
  output logic                  pop,
  rtdc_out_if.source            result
);
  import rtdc_pkg::*;

  localparam int MAG_W  = DIFF100_W + TEMP_FRAC_BITS + 1;
  localparam int YF_W   = MAG_W - DEN_SHIFT;
  localparam int MAX_W  = (YF_W > Y_W) ? YF_W : Y_W;

  logic                     en;
  logic                     sq_vld;
  logic [ROOT_W-1:0]        sq_root;
  rtdc_tag_t                sq_tag;

  logic                     s1_vld;
  logic [ROOT_W-1:0]        s1_diff;
  logic                     s1_neg;
  rtdc_tag_t                s1_tag;
  logic                     s2_vld;
  logic [Y_W-1:0]           s2_y;
  logic                     s2_neg;
  rtdc_tag_t                s2_tag;
  logic                     s3_vld;
  logic [Y_W-1:0]           s3_y;
  logic [Q_W-1:0]           s3_q0;
  logic                     s3_neg;
  rtdc_tag_t                s3_tag;
  logic                     s4_vld;
  logic [Q_W-1:0]           s4_q;
  logic                     s4_neg;
  rtdc_tag_t                s4_tag;
  logic                     out_vld;

  logic [DIFF100_W-1:0]     diff100;
  logic [MAG_W-1:0]         mag;
  logic [YF_W-1:0]          y_full;
  logic [Y_W-1:0]           y_clamp;
  logic [RECIP_PROD_W-1:0]  recip_prod;
  logic [Y_W:0]             rem;
  logic [Q_W-1:0]           mag_sat;
  logic [TEMP_W-1:0]        temp_bits;

  assign en  = !out_vld || result.ready;
  assign pop = en && !qstat.empty;

  rtdc_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pop),
    .in_rad    ({1'b0, head.disc, {SQRT_SHIFT{1'b0}}}),
    .in_tag    (head.tag),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_tag   (sq_tag)
  );

  // rounding offset, then divide by 1155 * 2^16 via shift and reciprocal
  always_comb begin
    diff100    = DIFF100_W'(s1_diff) * DIFF100_W'(HUNDRED);
    mag        = (MAG_W'(diff100) << TEMP_FRAC_BITS) + MAG_W'(DEN_HALF);
    y_full     = mag[MAG_W-1:DEN_SHIFT];
    y_clamp    = (MAX_W'(y_full) >= MAX_W'(SAT_Y)) ? SAT_Y : Y_W'(y_full);
    recip_prod = RECIP_PROD_W'(s2_y) * RECIP_PROD_W'(RECIP);
    rem        = (Y_W + 1)'(s3_y) - (Y_W + 1)'((Y_W + 1)'(s3_q0) * (Y_W + 1)'(DIV_K));
  end

  // saturate, apply sign, and force zero for a negative discriminant
  always_comb begin
    if (s4_neg) begin
      mag_sat   = (s4_q > TEMP_NEG_MAG) ? TEMP_NEG_MAG : s4_q;
      temp_bits = TEMP_W'(0) - TEMP_W'(mag_sat);
    end else begin
      mag_sat   = (s4_q > TEMP_POS_MAX) ? TEMP_POS_MAX : s4_q;
      temp_bits = TEMP_W'(mag_sat);
    end
    if (!s4_tag.disc_ok) begin
      temp_bits = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      s2_vld  <= 1'b0;
      s3_vld  <= 1'b0;
      s4_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      s1_vld  <= sq_vld;
      s2_vld  <= s1_vld;
      s3_vld  <= s2_vld;
      s4_vld  <= s3_vld;
      out_vld <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_neg  <= sq_root > A_SCALED;
      s1_diff <= (sq_root > A_SCALED) ? sq_root - A_SCALED : A_SCALED - sq_root;
      s1_tag  <= sq_tag;
      s2_y    <= y_clamp;
      s2_neg  <= s1_neg;
      s2_tag  <= s1_tag;
      s3_y    <= s2_y;
      s3_q0   <= recip_prod[RECIP_SHIFT +: Q_W];
      s3_neg  <= s2_neg;
      s3_tag  <= s2_tag;
      s4_q    <= (rem >= (Y_W + 1)'(DIV_K)) ? s3_q0 + 1'b1 : s3_q0;
      s4_neg  <= s3_neg;
      s4_tag  <= s3_tag;
      result.temperature <= $signed(temp_bits);
      result.valid_res   <= s4_tag.disc_ok;
      result.fault       <= s4_tag.fault;
    end
  end

  assign result.valid = out_vld;

endmodule

FILE: hw/rtl/rtd_temperature_converter_unit.sv
// ----------------------------------------------------------------------------
// rtd_temperature_converter_unit: pt100 resistance to temperature converter
// throughput: one beat per cycle unless stalled, set by the fully pipelined
//   square root
// stall: a held result stops the back pipeline; the front keeps filling a
//   four-entry queue and stalls only once it is full
// reset: rst synchronous, clears all valid bits and loads reference_ohms 400
// ----------------------------------------------------------------------------
module rtd_temperature_converter_unit #(
  parameter int TEMP_FRAC_BITS = 6
) (
  input  logic                         clk,
  input  logic                         rst,
  rtdc_in_if.sink                      item,
  rtdc_out_if.source                   result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rtdc_pkg::PADDR_W-1:0] paddr,
  input  logic [rtdc_pkg::PDATA_W-1:0] pwdata,
  output logic [rtdc_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import rtdc_pkg::*;

  // configuration: single register, reference resistor in ohms
  logic [REF_W-1:0] reference_ohms;
  logic             cfg_wr;

  // front to queue to back
  logic        q_push;
  logic        q_pop;
  rtdc_entry_t q_wr_entry;
  rtdc_entry_t q_head;
  rtdc_qstat_t qstat;

  // apb access: write lands in the access phase, no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_REF_OHMS);
  assign prdata = (paddr == ADDR_REF_OHMS) ? PDATA_W'(reference_ohms) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_ohms <= REF_RESET;
    end else if (cfg_wr) begin
      reference_ohms <= pwdata[REF_W-1:0];
    end
  end

  // front: code times reference, slope product, discriminant sign
  rtdc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .ref_ohms (reference_ohms),
    .qstat    (qstat),
    .push     (q_push),
    .entry    (q_wr_entry)
  );

  // queue lets front and back stall independently
  rtdc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .pop      (q_pop),
    .rd_entry (q_head),
    .qstat    (qstat)
  );

  // back: 16-stage square root, scaling to 1/2^frac degC, saturation,
  // result register
  rtdc_back #(
    .TEMP_FRAC_BITS (TEMP_FRAC_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (q_head),
    .qstat  (qstat),
    .pop    (q_pop),
    .result (result)
  );

  // queue never takes a beat while full, never gives one while empty
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    q_push |-> !qstat.full)
    else $error("queue push while full");

  a_no_underflow : assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !qstat.empty)
    else $error("queue pop while empty");

  // a held result freezes the back pipeline
  a_back_stall : assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !q_pop)
    else $error("back pipeline advanced under a stalled result");

  // negative discriminant reports zero temperature
  a_invalid_zero : assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.valid_res) |-> (result.temperature == '0))
    else $error("invalid result with nonzero temperature");

endmodule
